// ----- rtl/htf_pkg.sv -----
// htf_pkg: shared types and constants of the homogeneous 3D transform unit.
// Used by htf_dot, htf_div_step and homogeneous_transform_3d; no dependencies.
`timescale 1ns / 1ps

package htf_pkg;

  // default field widths
  localparam int unsigned COORD_WIDTH = 32;   // Q16.16 coordinates
  localparam int unsigned COEF_WIDTH  = 16;   // Q8.8 coefficients

  // fixed-point layout
  localparam int unsigned COEF_FRAC  = 8;     // fraction bits of a coefficient
  localparam int unsigned COORD_FRAC = 16;    // fraction bits of a coordinate
  localparam int unsigned COEF_SLOT  = 16;    // bit pitch of a coefficient in a row register
  localparam int unsigned COEF_ONE   = 256;   // 1.0 in Q8.8

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned FWD_ROWS   = 4;
  localparam int unsigned FWD_COLS   = 4;
  localparam int unsigned INV_ROWS   = 3;
  localparam int unsigned INV_COLS   = 3;
  localparam int unsigned LANES      = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FWD_ROW0 = 3'd0,
    REG_FWD_ROW1 = 3'd1,
    REG_FWD_ROW2 = 3'd2,
    REG_FWD_ROW3 = 3'd3,
    REG_INV_ROW0 = 3'd4,
    REG_INV_ROW1 = 3'd5,
    REG_INV_ROW2 = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    FUNC_POINT  = 2'd0,
    FUNC_VECTOR = 2'd1,
    FUNC_NORMAL = 2'd2
  } func_e;

  // sideband that travels with an item through the divider stages
  typedef struct packed {
    logic             pt;    // item is a point
    logic             wz;    // homogeneous w is zero
    logic [LANES-1:0] neg;   // quotient sign per lane
    logic [LANES-1:0] ovf;   // quotient saturates per lane
  } div_ctl_t;

endpackage

// ----- rtl/htf_dot.sv -----
// htf_dot: one row dot product c0*x + c1*y + c2*z + t, floored to Q.16.
// Two register stages (products, then sum). Depends on htf_pkg.
`timescale 1ns / 1ps

module htf_dot #(
  parameter int unsigned COORD_WIDTH = htf_pkg::COORD_WIDTH,
  parameter int unsigned COEF_WIDTH  = htf_pkg::COEF_WIDTH
) (
  input  logic                                         clk_i,
  input  logic                                         mul_en_i,
  input  logic                                         sum_en_i,
  input  logic signed [COEF_WIDTH-1:0]                 coef_i [3],
  input  logic signed [COEF_WIDTH-1:0]                 trans_i,
  input  logic signed [COORD_WIDTH-1:0]                crd_i  [3],
  output logic signed [COORD_WIDTH+COEF_WIDTH-7:0]     dot_o
);

  localparam int unsigned PROD_W = COORD_WIDTH + COEF_WIDTH;
  localparam int unsigned SUM_W  = PROD_W + 2;
  localparam int unsigned DOT_W  = SUM_W - htf_pkg::COEF_FRAC;

  logic signed [PROD_W-1:0]     prod_q [3];
  logic signed [COEF_WIDTH-1:0] trans_q;
  logic signed [SUM_W-1:0]      sum_d;
  logic signed [DOT_W-1:0]      dot_q;

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      for (int j = 0; j < 3; j++) begin
        prod_q[j] <= coef_i[j] * crd_i[j];
      end
      trans_q <= trans_i;
    end
  end

  // exact sum with 24 fraction bits (the Q8.8 translation moves up by 16);
  // an arithmetic shift floors to 16 fraction bits
  always_comb begin
    sum_d = SUM_W'(prod_q[0]) + SUM_W'(prod_q[1]) + SUM_W'(prod_q[2])
          + (SUM_W'(trans_q) <<< htf_pkg::COORD_FRAC);
  end

  always_ff @(posedge clk_i) begin
    if (sum_en_i) begin
      dot_q <= sum_d[SUM_W-1:htf_pkg::COEF_FRAC];
    end
  end

  assign dot_o = dot_q;

endmodule

// ----- rtl/htf_div_step.sv -----
// htf_div_step: one restoring-division stage, one quotient bit for three lanes.
// Registers remainder, quotient and sideband. Depends on htf_pkg.
`timescale 1ns / 1ps

module htf_div_step #(
  parameter int unsigned COORD_WIDTH = htf_pkg::COORD_WIDTH,
  parameter int unsigned COEF_WIDTH  = htf_pkg::COEF_WIDTH
) (
  input  logic                                      clk_i,
  input  logic                                      en_i,
  input  htf_pkg::div_ctl_t                         ctl_i,
  input  logic [COORD_WIDTH+COEF_WIDTH-7:0]         den_i,
  input  logic [2*COORD_WIDTH+COEF_WIDTH-7:0]       rem_i [3],
  input  logic [COORD_WIDTH-2:0]                    quo_i [3],
  input  logic [COORD_WIDTH-1:0]                    byp_i [3],
  output htf_pkg::div_ctl_t                         ctl_o,
  output logic [COORD_WIDTH+COEF_WIDTH-7:0]         den_o,
  output logic [2*COORD_WIDTH+COEF_WIDTH-7:0]       rem_o [3],
  output logic [COORD_WIDTH-2:0]                    quo_o [3],
  output logic [COORD_WIDTH-1:0]                    byp_o [3]
);

  localparam int unsigned DOT_W = COORD_WIDTH + COEF_WIDTH - 6;
  localparam int unsigned QUO_W = COORD_WIDTH - 1;
  localparam int unsigned REM_W = DOT_W + COORD_WIDTH;

  logic [REM_W-1:0] dtop;
  logic [REM_W-1:0] rem_d [3];
  logic [QUO_W-1:0] quo_d [3];
  logic             ge    [3];

  // divisor aligned to the top quotient bit; remainder shifts up each stage
  always_comb begin
    dtop = REM_W'(den_i) << (QUO_W - 1);
    for (int l = 0; l < 3; l++) begin
      ge[l]    = rem_i[l] >= dtop;
      rem_d[l] = (ge[l] ? (rem_i[l] - dtop) : rem_i[l]) << 1;
      quo_d[l] = {quo_i[l][QUO_W-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_o <= ctl_i;
      den_o <= den_i;
      for (int l = 0; l < 3; l++) begin
        rem_o[l] <= rem_d[l];
        quo_o[l] <= quo_d[l];
        byp_o[l] <= byp_i[l];
      end
    end
  end

endmodule

// ----- rtl/homogeneous_transform_3d.sv -----
// homogeneous_transform_3d: top level of the 4x4 homogeneous transform unit.
// Depends on htf_pkg, htf_dot and htf_div_step.
`timescale 1ns / 1ps

// Transforms one 3D item per clock while not stalled. tuser on the input
// selects the kind: point (full 4x4 matrix, then divide by w), direction
// vector (upper 3x3 of the forward matrix) or surface normal (transpose of
// the stored 3x3 inverse); kind 3 gives zeros. Coordinates are signed Q16.16,
// coefficients signed Q8.8; results saturate. A point with w == 0 returns
// zeros with w_zero set in the output tuser. Throughput is one transfer per
// cycle while the output buffer has room; the divider resolves one quotient
// bit per stage for the three lanes in parallel. Stages: products, row sums,
// divide prep, COORD_WIDTH-1 divide steps, result format, output register.
// A two-entry output buffer lets the unit keep taking input while one result
// waits; s_axis_tready only drops once the second entry fills. Matrix
// registers are written through cfg_*; the user must do so only while no
// transfer is in flight; the unit does not enforce it. They reset to identity.
module homogeneous_transform_3d #(
  parameter int unsigned COORD_WIDTH = htf_pkg::COORD_WIDTH,
  parameter int unsigned COEF_WIDTH  = htf_pkg::COEF_WIDTH
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration writes
  input  logic                                  cfg_we_i,
  input  logic [htf_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [htf_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  // input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]    s_axis_tdata,  // in_x, in_y, in_z
  input  logic [1:0]                            s_axis_tuser,  // func
  // result stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0]    m_axis_tdata,  // out_x, out_y, out_z
  output logic                                  m_axis_tuser   // w_zero
);

  localparam int unsigned PROD_W  = COORD_WIDTH + COEF_WIDTH;
  localparam int unsigned DOT_W   = PROD_W + 2 - htf_pkg::COEF_FRAC;
  localparam int unsigned QUO_W   = COORD_WIDTH - 1;
  localparam int unsigned REM_W   = DOT_W + COORD_WIDTH;
  localparam int unsigned TDATA_W = ((3*COORD_WIDTH+7)/8)*8;
  localparam int unsigned NS      = QUO_W + 4;   // stages with a valid bit

  localparam logic [COORD_WIDTH-1:0] SAT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] SAT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic signed [COEF_WIDTH-1:0] C_ONE  = COEF_WIDTH'(htf_pkg::COEF_ONE);
  localparam logic signed [COEF_WIDTH-1:0] C_ZERO = '0;

  // ---------------------------------------------------------------------------
  // Matrix registers (only the coefficient bits of each slot are kept)
  // ---------------------------------------------------------------------------
  logic signed [COEF_WIDTH-1:0] fwd_q [htf_pkg::FWD_ROWS][htf_pkg::FWD_COLS];
  logic signed [COEF_WIDTH-1:0] inv_q [htf_pkg::INV_ROWS][htf_pkg::INV_COLS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < htf_pkg::FWD_ROWS; r++) begin
        for (int c = 0; c < htf_pkg::FWD_COLS; c++) begin
          fwd_q[r][c] <= (r == c) ? C_ONE : C_ZERO;
        end
      end
      for (int r = 0; r < htf_pkg::INV_ROWS; r++) begin
        for (int c = 0; c < htf_pkg::INV_COLS; c++) begin
          inv_q[r][c] <= (r == c) ? C_ONE : C_ZERO;
        end
      end
    end else if (cfg_we_i) begin
      unique case (cfg_index_i) inside
        htf_pkg::REG_FWD_ROW0, htf_pkg::REG_FWD_ROW1,
        htf_pkg::REG_FWD_ROW2, htf_pkg::REG_FWD_ROW3: begin
          for (int c = 0; c < htf_pkg::FWD_COLS; c++) begin
            fwd_q[cfg_index_i[1:0]][c] <= cfg_data_i[htf_pkg::COEF_SLOT*c +: COEF_WIDTH];
          end
        end
        // inverse rows 0..2 sit at indexes 4..6, so the low bits pick the row
        htf_pkg::REG_INV_ROW0, htf_pkg::REG_INV_ROW1, htf_pkg::REG_INV_ROW2: begin
          for (int c = 0; c < htf_pkg::INV_COLS; c++) begin
            inv_q[cfg_index_i[1:0]][c] <= cfg_data_i[htf_pkg::COEF_SLOT*c +: COEF_WIDTH];
          end
        end
        default: ;  // out-of-range index ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage control: one enable for the whole pipe, held off only when the
  // output buffer is full. Valid bits shift along with the data.
  // ---------------------------------------------------------------------------
  logic          en;
  logic [NS-1:0] v_q;
  logic [1:0]    pt_q;      // point flag for the product and sum stages
  logic          o_v_q, k_v_q;

  assign en            = !k_v_q;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NS-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pt_q <= {pt_q[0], s_axis_tuser == htf_pkg::FUNC_POINT};
    end
  end

  // ---------------------------------------------------------------------------
  // Coefficient selection by kind, then four dot-product rows (x, y, z, w)
  // ---------------------------------------------------------------------------
  logic signed [COEF_WIDTH-1:0]  cf  [4][3];
  logic signed [COEF_WIDTH-1:0]  tr  [4];
  logic signed [COORD_WIDTH-1:0] crd [3];
  logic signed [DOT_W-1:0]       dot_w [4];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      crd[l] = $signed(s_axis_tdata[l*COORD_WIDTH +: COORD_WIDTH]);
    end
    for (int r = 0; r < 4; r++) begin
      tr[r] = '0;
      for (int j = 0; j < 3; j++) begin
        cf[r][j] = '0;
      end
    end
    unique case (s_axis_tuser)
      htf_pkg::FUNC_POINT: begin
        for (int r = 0; r < 4; r++) begin
          tr[r] = fwd_q[r][3];
          for (int j = 0; j < 3; j++) begin
            cf[r][j] = fwd_q[r][j];
          end
        end
      end
      htf_pkg::FUNC_VECTOR: begin
        for (int r = 0; r < 3; r++) begin
          for (int j = 0; j < 3; j++) begin
            cf[r][j] = fwd_q[r][j];
          end
        end
      end
      htf_pkg::FUNC_NORMAL: begin
        // transpose of the inverse
        for (int r = 0; r < 3; r++) begin
          for (int j = 0; j < 3; j++) begin
            cf[r][j] = inv_q[j][r];
          end
        end
      end
      default: ;  // unused kind: all-zero coefficients give zero results
    endcase
  end

  for (genvar r = 0; r < 4; r++) begin : g_row
    htf_dot #(
      .COORD_WIDTH (COORD_WIDTH),
      .COEF_WIDTH  (COEF_WIDTH)
    ) u_dot (
      .clk_i    (clk_i),
      .mul_en_i (en),
      .sum_en_i (en),
      .coef_i   (cf[r]),
      .trans_i  (tr[r]),
      .crd_i    (crd),
      .dot_o    (dot_w[r])
    );
  end

  // ---------------------------------------------------------------------------
  // Divide prep: magnitudes, signs, saturation check, bypass results
  // ---------------------------------------------------------------------------
  htf_pkg::div_ctl_t      ctl_s [QUO_W+1];
  logic [DOT_W-1:0]       den_s [QUO_W+1];
  logic [REM_W-1:0]       rem_s [QUO_W+1][3];
  logic [QUO_W-1:0]       quo_s [QUO_W+1][3];
  logic [COORD_WIDTH-1:0] byp_s [QUO_W+1][3];

  htf_pkg::div_ctl_t      prep_ctl;
  logic [DOT_W-1:0]       wabs;
  logic [DOT_W-1:0]       nabs [3];
  logic [REM_W-1:0]       num  [3];
  logic [COORD_WIDTH-1:0] byp  [3];
  logic [REM_W-1:0]       dlim;

  always_comb begin
    wabs          = dot_w[3][DOT_W-1] ? DOT_W'(-dot_w[3]) : DOT_W'(dot_w[3]);
    dlim          = REM_W'(wabs) << QUO_W;   // quotient at or past full scale
    prep_ctl.pt   = pt_q[1];
    prep_ctl.wz   = (dot_w[3] == '0);
    for (int l = 0; l < 3; l++) begin
      nabs[l] = dot_w[l][DOT_W-1] ? DOT_W'(-dot_w[l]) : DOT_W'(dot_w[l]);
      num[l]  = REM_W'({nabs[l], {htf_pkg::COORD_FRAC{1'b0}}});
      prep_ctl.neg[l] = dot_w[l][DOT_W-1] ^ dot_w[3][DOT_W-1];
      prep_ctl.ovf[l] = num[l] >= dlim;
      if (dot_w[l][DOT_W-1:COORD_WIDTH-1] == {(DOT_W-COORD_WIDTH+1){dot_w[l][DOT_W-1]}}) begin
        byp[l] = dot_w[l][COORD_WIDTH-1:0];
      end else begin
        byp[l] = dot_w[l][DOT_W-1] ? SAT_MIN : SAT_MAX;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctl_s[0] <= prep_ctl;
      den_s[0] <= wabs;
      for (int l = 0; l < 3; l++) begin
        rem_s[0][l] <= num[l];
        quo_s[0][l] <= '0;
        byp_s[0][l] <= byp[l];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Divider: one quotient bit per stage, MSB first
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    htf_div_step #(
      .COORD_WIDTH (COORD_WIDTH),
      .COEF_WIDTH  (COEF_WIDTH)
    ) u_step (
      .clk_i (clk_i),
      .en_i  (en),
      .ctl_i (ctl_s[k]),
      .den_i (den_s[k]),
      .rem_i (rem_s[k]),
      .quo_i (quo_s[k]),
      .byp_i (byp_s[k]),
      .ctl_o (ctl_s[k+1]),
      .den_o (den_s[k+1]),
      .rem_o (rem_s[k+1]),
      .quo_o (quo_s[k+1]),
      .byp_o (byp_s[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Result format: sign, saturation, zero-w and kind selection
  // ---------------------------------------------------------------------------
  htf_pkg::div_ctl_t      fc;
  logic [COORD_WIDTH-1:0] mag   [3];
  logic [COORD_WIDTH-1:0] fmt_d [3];
  logic [COORD_WIDTH-1:0] fmt_q [3];
  logic                   fmt_wz_q;

  always_comb begin
    fc = ctl_s[QUO_W];
    for (int l = 0; l < 3; l++) begin
      mag[l] = {1'b0, quo_s[QUO_W][l]};
      if (!fc.pt) begin
        fmt_d[l] = byp_s[QUO_W][l];
      end else if (fc.wz) begin
        fmt_d[l] = '0;
      end else if (fc.ovf[l]) begin
        fmt_d[l] = fc.neg[l] ? SAT_MIN : SAT_MAX;
      end else begin
        fmt_d[l] = fc.neg[l] ? COORD_WIDTH'(-mag[l]) : mag[l];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fmt_q    <= fmt_d;
      fmt_wz_q <= fc.pt && fc.wz;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register plus skid entry
  // ---------------------------------------------------------------------------
  logic [COORD_WIDTH-1:0] o_q [3];
  logic [COORD_WIDTH-1:0] k_q [3];
  logic                   o_wz_q, k_wz_q;
  logic                   last_v;

  assign last_v = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
      k_v_q <= 1'b0;
    end else if (en && last_v) begin
      if (!o_v_q || m_axis_tready) begin
        o_v_q <= 1'b1;
      end else begin
        k_v_q <= 1'b1;
      end
    end else if (o_v_q && m_axis_tready) begin
      if (k_v_q) begin
        k_v_q <= 1'b0;
      end else begin
        o_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && last_v) begin
      if (!o_v_q || m_axis_tready) begin
        o_q    <= fmt_q;
        o_wz_q <= fmt_wz_q;
      end else begin
        k_q    <= fmt_q;
        k_wz_q <= fmt_wz_q;
      end
    end else if (o_v_q && m_axis_tready && k_v_q) begin
      o_q    <= k_q;
      o_wz_q <= k_wz_q;
    end
  end

  assign m_axis_tvalid = o_v_q;
  assign m_axis_tdata  = TDATA_W'({o_q[2], o_q[1], o_q[0]});
  assign m_axis_tuser  = o_wz_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // the skid entry only fills behind a held output
  assert property (@(posedge clk_i) disable iff (!rst_ni) k_v_q |-> o_v_q)
    else $error("skid entry valid without output valid");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $rose(k_v_q) |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("skid entry filled while output was free");

  // zero-w results carry zero coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("w_zero set with nonzero coordinates");

  // after the last step the remainder stays below the scaled divisor
  for (genvar l = 0; l < 3; l++) begin : g_chk
    assert property (@(posedge clk_i) disable iff (!rst_ni)
                     v_q[NS-2] && ctl_s[QUO_W].pt && !ctl_s[QUO_W].wz && !ctl_s[QUO_W].ovf[l]
                     |-> rem_s[QUO_W][l] < (REM_W'(den_s[QUO_W]) << QUO_W))
      else $error("divider remainder out of range");
  end

endmodule

// ----- verif/tb_homogeneous_transform_3d.sv -----
// tb_homogeneous_transform_3d: self-checking testbench of the homogeneous 3D transform unit.
// Depends on htf_pkg and homogeneous_transform_3d; stand-alone, no files read.
`timescale 1ns / 1ps

module tb_homogeneous_transform_3d;

  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned RESET_CYCLES = 7;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 128;
  localparam int unsigned HOLD_CYCLES  = 200;       // long output stall in the first phase
  localparam int unsigned DRAIN_CYCLES = 60;        // settle time before the final report
  localparam int unsigned WATCHDOG_NS  = 3_000_000; // far beyond the slowest run
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned CW           = htf_pkg::COORD_WIDTH;

  // kind 3 has no enum member; the unit answers it with zeros
  localparam logic [1:0]                    FUNC_UNUSED = 2'd3;
  // config index past the last register; writes to it are dropped
  localparam logic [htf_pkg::CFG_IDX_W-1:0] REG_NONE    = 3'd7;
  localparam logic [63:0]                   INV_MASK    = 64'h0000_FFFF_FFFF_FFFF;

  // one input transfer: tuser on top, tdata below (x in the low bits)
  typedef struct packed {
    logic [1:0]    kind;
    logic [CW-1:0] z, y, x;
  } coord_item_t;

  // one result transfer: w_zero (tuser) on top of out_z, out_y, out_x
  typedef struct packed {
    logic          wz;
    logic [CW-1:0] z, y, x;
  } xform_t;

  logic                             clk_i         = 1'b0;
  logic                             rst_ni        = 1'b0;
  logic                             cfg_we_i      = 1'b0;
  logic [htf_pkg::CFG_IDX_W-1:0]    cfg_index_i   = '0;
  logic [htf_pkg::CFG_DATA_W-1:0]   cfg_data_i    = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [3*CW-1:0]                  s_axis_tdata  = '0;  // in_x, in_y, in_z
  logic [1:0]                       s_axis_tuser  = '0;  // func
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [3*CW-1:0]                  m_axis_tdata;        // out_x, out_y, out_z
  logic                             m_axis_tuser;        // w_zero

  homogeneous_transform_3d dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow of the matrix registers, indexed by register index. Only updated
  // while the unit is idle, so it is valid for every transfer in flight.
  // ---------------------------------------------------------------------------
  logic [63:0] mat_reg [htf_pkg::FWD_ROWS + htf_pkg::INV_ROWS];

  coord_item_t coord_q [$];    // items waiting to be offered
  xform_t      xformed_q [$];  // transformed results still owed by the unit

  // traffic shaping, changed only between phases
  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  logic        hold_req      = 1'b0;
  logic        hold_taken    = 1'b0;
  int unsigned hold_left     = 0;

  // bookkeeping
  int unsigned mismatch_cnt = 0;
  int unsigned n_point = 0, n_vector = 0, n_normal = 0, n_unused = 0, n_wzero = 0;
  int unsigned cfg_sets = 0;
  int unsigned backpressure_cycles = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic longint coef_at(int unsigned r, int unsigned c);
    logic [htf_pkg::COEF_WIDTH-1:0] raw;
    raw = mat_reg[r][c*htf_pkg::COEF_SLOT +: htf_pkg::COEF_WIDTH];
    return longint'($signed(raw));
  endfunction

  // Q8.8 x Q16.16 products carry 24 fraction bits; the exact sum is floored
  // back to 16, then the translation (Q8.8 -> Q16.16) is added.
  function automatic longint row_sum(input longint c0, c1, c2, t, x, y, z);
    return (t <<< htf_pkg::COEF_FRAC) + ((c0 * x + c1 * y + c2 * z) >>> htf_pkg::COEF_FRAC);
  endfunction

  function automatic logic [CW-1:0] clamp_coord(longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    else if (v < lo) v = lo;
    return v[CW-1:0];
  endfunction

  // quotient with 16 fraction bits, truncated toward zero; |n| stays below
  // 2^40, so the shifted numerator cannot overflow 64 bits
  function automatic logic [CW-1:0] divide_q16(longint n, longint d);
    logic            neg;
    longint unsigned an, ad, mag;
    neg = (n < 0) != (d < 0);
    an  = (n < 0) ? -n : n;
    ad  = (d < 0) ? -d : d;
    mag = (an << htf_pkg::COORD_FRAC) / ad;
    return clamp_coord(neg ? -longint'(mag) : longint'(mag));
  endfunction

  function automatic xform_t transform_coord(coord_item_t it);
    longint x, y, z, w;
    logic [CW-1:0] lane [htf_pkg::LANES];
    xform_t res;
    x   = longint'($signed(it.x));
    y   = longint'($signed(it.y));
    z   = longint'($signed(it.z));
    res = '0;
    for (int i = 0; i < htf_pkg::LANES; i++) lane[i] = '0;
    case (it.kind)
      htf_pkg::FUNC_POINT: begin
        w = row_sum(coef_at(htf_pkg::REG_FWD_ROW3, 0), coef_at(htf_pkg::REG_FWD_ROW3, 1),
                    coef_at(htf_pkg::REG_FWD_ROW3, 2), coef_at(htf_pkg::REG_FWD_ROW3, 3),
                    x, y, z);
        if (w == 0) begin
          res.wz = 1'b1;
        end else begin
          for (int i = 0; i < htf_pkg::LANES; i++)
            lane[i] = divide_q16(row_sum(coef_at(htf_pkg::REG_FWD_ROW0 + i, 0),
                                         coef_at(htf_pkg::REG_FWD_ROW0 + i, 1),
                                         coef_at(htf_pkg::REG_FWD_ROW0 + i, 2),
                                         coef_at(htf_pkg::REG_FWD_ROW0 + i, 3), x, y, z), w);
        end
      end
      htf_pkg::FUNC_VECTOR: begin
        for (int i = 0; i < htf_pkg::LANES; i++)
          lane[i] = clamp_coord(row_sum(coef_at(htf_pkg::REG_FWD_ROW0 + i, 0),
                                        coef_at(htf_pkg::REG_FWD_ROW0 + i, 1),
                                        coef_at(htf_pkg::REG_FWD_ROW0 + i, 2), 0, x, y, z));
      end
      htf_pkg::FUNC_NORMAL: begin
        // transpose of the inverse: lane i takes column i of the stored rows
        for (int i = 0; i < htf_pkg::LANES; i++)
          lane[i] = clamp_coord(row_sum(coef_at(htf_pkg::REG_INV_ROW0, i),
                                        coef_at(htf_pkg::REG_INV_ROW1, i),
                                        coef_at(htf_pkg::REG_INV_ROW2, i), 0, x, y, z));
      end
      default: ;
    endcase
    res.x = lane[0];
    res.y = lane[1];
    res.z = lane[2];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: holds an offered item until it transfers, then may idle.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive_in
    coord_item_t it;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (coord_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        it = coord_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.z, it.y, it.x};
        s_axis_tuser  <= it.kind;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output ready: random stalls, plus one long hold-off requested once.
  always @(posedge clk_i) begin
    if (hold_req && !hold_taken) begin
      hold_taken    <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result transfer against the oldest prediction, then
  // predicts for an input transfer at the same edge. One process, no race.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch
    xform_t      got, want;
    coord_item_t seen;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata};
        if (xformed_q.size() == 0) begin
          if (mismatch_cnt < MAX_REPORTS)
            $display("unexpected result at %0t: x=%h y=%h z=%h w_zero=%b",
                     $time, got.x, got.y, got.z, got.wz);
          mismatch_cnt++;
        end else begin
          want = xformed_q.pop_front();
          if (got.x != want.x || got.y != want.y || got.z != want.z
              || got.wz != want.wz) begin
            if (mismatch_cnt < MAX_REPORTS)
              $display({"mismatch at %0t: want x=%h y=%h z=%h w_zero=%b,",
                        " got x=%h y=%h z=%h w_zero=%b"},
                       $time, want.x, want.y, want.z, want.wz,
                       got.x, got.y, got.z, got.wz);
            mismatch_cnt++;
          end
        end
      end
      if (s_axis_tvalid && !s_axis_tready) backpressure_cycles++;
      if (s_axis_tvalid && s_axis_tready) begin
        seen = {s_axis_tuser, s_axis_tdata};
        want = transform_coord(seen);
        xformed_q.push_back(want);
        if (want.wz) n_wzero++;
        case (seen.kind)
          htf_pkg::FUNC_POINT:  n_point++;
          htf_pkg::FUNC_VECTOR: n_vector++;
          htf_pkg::FUNC_NORMAL: n_normal++;
          default:              n_unused++;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_coord(logic [1:0] kind, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    coord_item_t it;
    it = '{kind: kind, z: z, y: y, x: x};
    coord_q.push_back(it);
  endtask

  // single config write; the shadow follows the unit's masking rules
  task automatic write_reg(logic [htf_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    if (idx <= htf_pkg::REG_FWD_ROW3) mat_reg[idx] = val;
    else if (idx <= htf_pkg::REG_INV_ROW2) mat_reg[idx] = val & INV_MASK;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_matrix(logic [63:0] f0, f1, f2, f3, i0, i1, i2);
    write_reg(htf_pkg::REG_FWD_ROW0, f0);
    write_reg(htf_pkg::REG_FWD_ROW1, f1);
    write_reg(htf_pkg::REG_FWD_ROW2, f2);
    write_reg(htf_pkg::REG_FWD_ROW3, f3);
    write_reg(htf_pkg::REG_INV_ROW0, i0);
    write_reg(htf_pkg::REG_INV_ROW1, i1);
    write_reg(htf_pkg::REG_INV_ROW2, i2);
    cfg_sets++;
  endtask

  // wait at falling edges so queue and valid are settled
  task automatic wait_idle();
    do @(negedge clk_i);
    while (coord_q.size() != 0 || s_axis_tvalid || xformed_q.size() != 0);
  endtask

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(15))
      0:                   return 16'h0000;
      1:                   return 16'h7FFF;
      2:                   return 16'h8000;
      3:                   return 16'hFFFF;
      4, 5, 6, 7, 8, 9:    return 16'($urandom_range(1024) - 512);  // within +-2.0
      default:             return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(15))
      0:                   return 32'h0000_0000;
      1:                   return 32'h7FFF_FFFF;
      2:                   return 32'h8000_0000;
      3:                   return 32'hFFFF_FFFF;
      4, 5, 6, 7, 8, 9:    return 32'($urandom_range(32'h0010_0000) - 32'h0008_0000);
      default:             return $urandom;
    endcase
  endfunction

  function automatic logic [1:0] rand_kind();
    case ($urandom_range(7))
      0, 1, 2: return htf_pkg::FUNC_POINT;
      3, 4:    return htf_pkg::FUNC_VECTOR;
      5, 6:    return htf_pkg::FUNC_NORMAL;
      default: return FUNC_UNUSED;
    endcase
  endfunction

  function automatic logic [63:0] rand_row();
    return {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
  endfunction

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stim
    logic [63:0] w_row;
    for (int r = 0; r < htf_pkg::FWD_ROWS; r++)
      mat_reg[r] = 64'(htf_pkg::COEF_ONE) << (r * htf_pkg::COEF_SLOT);
    for (int r = 0; r < htf_pkg::INV_ROWS; r++)
      mat_reg[htf_pkg::REG_INV_ROW0 + r] = 64'(htf_pkg::COEF_ONE) << (r * htf_pkg::COEF_SLOT);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // identity matrices out of reset: w is 1.0, points come back unchanged
    add_coord(htf_pkg::FUNC_POINT,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    add_coord(htf_pkg::FUNC_POINT,  32'h0001_0000, 32'hFFFE_0000, 32'h0003_8000);
    add_coord(htf_pkg::FUNC_POINT,  32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    add_coord(htf_pkg::FUNC_POINT,  32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
    add_coord(htf_pkg::FUNC_VECTOR, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    add_coord(htf_pkg::FUNC_VECTOR, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
    add_coord(htf_pkg::FUNC_NORMAL, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
    add_coord(htf_pkg::FUNC_NORMAL, 32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA);
    add_coord(FUNC_UNUSED,          32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    wait_idle();

    // extreme coefficients, projective row zero: every point has zero w,
    // vectors and normals saturate; inverse writes carry junk in the top slot
    load_matrix(64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000, 64'h7FFF_8000_7FFF_8000,
                64'h0000_0000_0000_0000, 64'hFFFF_8000_8000_8000, 64'hFFFF_7FFF_7FFF_7FFF,
                64'hFFFF_8000_7FFF_8000);
    write_reg(REG_NONE, '1);  // out-of-range index must not disturb anything
    @(negedge clk_i);
    add_coord(htf_pkg::FUNC_POINT,  32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    add_coord(htf_pkg::FUNC_POINT,  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_coord(htf_pkg::FUNC_VECTOR, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_coord(htf_pkg::FUNC_VECTOR, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_coord(htf_pkg::FUNC_NORMAL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    add_coord(htf_pkg::FUNC_NORMAL, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    add_coord(FUNC_UNUSED,          32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    wait_idle();

    // w follows x: zero w at x == 0, one-LSB w blows the quotient up,
    // negative w flips signs; large translations in the top rows
    load_matrix(64'h7FFF_0000_0000_0100, 64'h8000_0000_0100_0000, 64'h0000_0100_0000_0000,
                64'h0000_0000_0000_0100, 64'h0000_0000_0000_FF00, 64'h0000_0000_0080_0000,
                64'h0000_7FFF_0000_0000);
    @(negedge clk_i);
    add_coord(htf_pkg::FUNC_POINT,  32'h0000_0000, 32'h0001_0000, 32'h0002_0000);
    add_coord(htf_pkg::FUNC_POINT,  32'h0000_0001, 32'h0001_0000, 32'h0000_0000);
    add_coord(htf_pkg::FUNC_POINT,  32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000);
    add_coord(htf_pkg::FUNC_POINT,  32'hFFFE_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    add_coord(htf_pkg::FUNC_POINT,  32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    add_coord(htf_pkg::FUNC_VECTOR, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    add_coord(htf_pkg::FUNC_NORMAL, 32'h0003_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    wait_idle();

    // random phases: fresh matrix each time, idle pattern rotates through
    // none / sender 76% / receiver 76% / both 11%
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 3)
        0:       w_row = 64'h0000_0000_0000_0100;                           // w = x
        1:       w_row = {16'h0100, rand_coef(), rand_coef(), rand_coef()}; // affine-like
        default: w_row = rand_row();
      endcase
      load_matrix(rand_row(), rand_row(), rand_row(), w_row,
                  {$urandom, $urandom}, {$urandom, $urandom},
                  {16'($urandom), rand_coef(), rand_coef(), rand_coef()});
      @(posedge clk_i);
      case (ph % 4)
        0:       begin src_idle_pct <= 0;  snk_stall_pct <= 0;  end
        1:       begin src_idle_pct <= 76; snk_stall_pct <= 0;  end
        2:       begin src_idle_pct <= 0;  snk_stall_pct <= 76; end
        default: begin src_idle_pct <= 11; snk_stall_pct <= 11; end
      endcase
      // first phase: sender runs flat out against a long output stall
      if (ph == 0) hold_req <= 1'b1;
      @(negedge clk_i);
      for (int n = 0; n < PHASE_ITEMS; n++)
        add_coord(rand_kind(), rand_coord(), rand_coord(), rand_coord());
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d points (%0d with zero w), %0d vectors, %0d normals, %0d kind-3 items",
             n_point, n_wzero, n_vector, n_normal, n_unused);
    $display("over %0d matrix settings; input stalled %0d cycles by output backpressure",
             cfg_sets, backpressure_cycles);
    if (mismatch_cnt == 0 && xformed_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(WATCHDOG_NS);
    $display("FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/htf_pkg.sv
rtl/htf_dot.sv
rtl/htf_div_step.sv
rtl/homogeneous_transform_3d.sv
verif/tb_homogeneous_transform_3d.sv
